// File: hw/rtl/pwes_pkg.sv
// Shared types and constants for the particle window event selector.
package pwes_pkg;

  localparam int TypeW      = 8;
  localparam int FieldEW    = 24;
  localparam int CntW       = 8;
  localparam int EvW        = 32;
  localparam int DataW      = 64;
  localparam int AddrW      = 6;
  localparam int NumCutRegs = 4;
  localparam int CutsW      = 3;

  localparam logic [2:0] REG_CUT_ZERO   = 3'd0;
  localparam logic [2:0] REG_CUT_ONE    = 3'd1;
  localparam logic [2:0] REG_CUT_TWO    = 3'd2;
  localparam logic [2:0] REG_CUT_THREE  = 3'd3;
  localparam logic [2:0] REG_CUTS_USE   = 3'd4;
  localparam logic [2:0] REG_REPORT_ORG = 3'd5;

  typedef struct packed {
    logic [TypeW-1:0]   ptype;
    logic [FieldEW-1:0] e_min;
    logic [FieldEW-1:0] e_max;
  } cut_t;

  typedef struct packed {
    cut_t [NumCutRegs-1:0] cut;
    logic [CutsW-1:0]      cuts_in_use;
    logic                  report_orig;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic pvalid;
    logic last;
  } stg_t;

endpackage

// File: hw/rtl/pwes_regs.sv
// Configuration register file behind the APB-style port.
module pwes_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwes_pkg::AddrW-1:0]    paddr,
  input  logic [pwes_pkg::DataW-1:0]    pwdata,
  output logic [pwes_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output pwes_pkg::cfg_t                cfg
);

  pwes_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[5:3];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pwes_pkg::NumCutRegs; i++) begin
        cfg_r.cut[i] <= '1;
      end
      cfg_r.cuts_in_use <= 3'd1;
      cfg_r.report_orig <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        pwes_pkg::REG_CUT_ZERO:   cfg_r.cut[0] <= pwdata[55:0];
        pwes_pkg::REG_CUT_ONE:    cfg_r.cut[1] <= pwdata[55:0];
        pwes_pkg::REG_CUT_TWO:    cfg_r.cut[2] <= pwdata[55:0];
        pwes_pkg::REG_CUT_THREE:  cfg_r.cut[3] <= pwdata[55:0];
        pwes_pkg::REG_CUTS_USE:   cfg_r.cuts_in_use <= pwdata[2:0];
        pwes_pkg::REG_REPORT_ORG: cfg_r.report_orig <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwes_pkg::REG_CUT_ZERO:   prdata = {8'd0, cfg_r.cut[0]};
      pwes_pkg::REG_CUT_ONE:    prdata = {8'd0, cfg_r.cut[1]};
      pwes_pkg::REG_CUT_TWO:    prdata = {8'd0, cfg_r.cut[2]};
      pwes_pkg::REG_CUT_THREE:  prdata = {8'd0, cfg_r.cut[3]};
      pwes_pkg::REG_CUTS_USE:   prdata = {61'd0, cfg_r.cuts_in_use};
      pwes_pkg::REG_REPORT_ORG: prdata = {63'd0, cfg_r.report_orig};
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/pwes_match.sv
// Compares one particle against one cut: type and inclusive energy window.
module pwes_match #(
  parameter int ENERGY_BITS = 24
) (
  input  pwes_pkg::cut_t                   cut,
  input  logic [pwes_pkg::TypeW-1:0]       ptype,
  input  logic [ENERGY_BITS-1:0]           energy,
  output logic                             hit
);

  logic [ENERGY_BITS-1:0] lo;
  logic [ENERGY_BITS-1:0] hi;

  assign lo  = cut.e_min[ENERGY_BITS-1:0];
  assign hi  = cut.e_max[ENERGY_BITS-1:0];
  assign hit = (cut.ptype == ptype) && (energy >= lo) && (energy <= hi);

endmodule

// File: hw/rtl/pwes_event.sv
// Per-event hit flags, distinct match count, event counters and result register.
module pwes_event #(
  parameter int MAX_CUTS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pwes_pkg::stg_t                 stg,
  input  logic [MAX_CUTS-1:0]            hit,
  input  logic [pwes_pkg::CutsW-1:0]     cuts_in_use,
  input  logic                           report_orig,
  input  logic                           out_stall,
  output logic                           adv,
  output logic                           out_valid,
  output logic                           out_event_passed,
  output logic [pwes_pkg::CntW-1:0]      out_matching_particles,
  output logic [pwes_pkg::EvW-1:0]       out_events_seen,
  output logic [pwes_pkg::EvW-1:0]       out_events_passed
);

  localparam logic [2:0] MaxN = 3'(MAX_CUTS);

  logic [MAX_CUTS-1:0]          flags_r, flags_nxt, act, hit_act;
  logic [pwes_pkg::CntW-1:0]    count_r, count_nxt;
  logic [pwes_pkg::EvW-1:0]     seen_r, seen_nxt, passed_r, passed_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         pass_r, pass_nxt;
  logic [pwes_pkg::CntW-1:0]    match_r;
  logic [pwes_pkg::EvW-1:0]     seen_out_r, passed_out_r;
  logic [2:0]                   n;
  logic                         out_free, load, passed;

  always_comb begin
    if (cuts_in_use == 3'd0) begin
      n = 3'd1;
    end else if (cuts_in_use > MaxN) begin
      n = MaxN;
    end else begin
      n = cuts_in_use;
    end
  end

  for (genvar i = 0; i < MAX_CUTS; i++) begin : g_act
    assign act[i] = (3'(i) < n);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = stg.valid && (!stg.last || out_free);
  assign load     = adv && stg.last;
  assign hit_act  = (stg.pvalid) ? (hit & act) : '0;

  always_comb begin
    flags_nxt = flags_r | hit_act;
    count_nxt = count_r;
    if ((|hit_act) && (count_r != '1)) begin
      count_nxt = count_r + 8'd1;
    end
    passed   = (&(flags_nxt | ~act)) && (count_nxt >= {5'd0, n});
    seen_nxt = (seen_r != '1) ? seen_r + 32'd1 : seen_r;
    passed_nxt = (passed && (passed_r != '1)) ? passed_r + 32'd1 : passed_r;
    pass_nxt = passed;
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      count_r     <= '0;
      seen_r      <= '0;
      passed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        if (stg.last) begin
          flags_r  <= '0;
          count_r  <= '0;
          seen_r   <= seen_nxt;
          passed_r <= passed_nxt;
        end else begin
          flags_r <= flags_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pass_r       <= pass_nxt;
      match_r      <= count_nxt;
      seen_out_r   <= report_orig ? seen_nxt : '0;
      passed_out_r <= passed_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_event_passed       = pass_r;
  assign out_matching_particles = match_r;
  assign out_events_seen        = seen_out_r;
  assign out_events_passed      = passed_out_r;

endmodule

// File: hw/rtl/particle_window_event_selector.sv
// Top level of the particle window event selector.
//
//   port group | direction | transaction
//   in_*       | input     | one particle of an event
//   out_*      | output    | one event result, sent on the last particle
//   APB port   | both      | configuration register write or read
//
// Particles pass through the input register, and the last of an event loads
// the result register; one particle is taken every cycle unless in_stall is
// high. The input register frees up once its particle retires, so a waiting
// result only holds the input side when a further last particle arrives.
// Reset is synchronous; it restores the configuration defaults and clears the
// event state, counters and valid flags.
module particle_window_event_selector #(
  parameter int MAX_CUTS    = 4,
  parameter int ENERGY_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pwes_pkg::TypeW-1:0]          in_particle_type,
  input  logic [pwes_pkg::FieldEW-1:0]        in_kinetic_energy,
  input  logic                                in_particle_valid,
  input  logic                                in_last_in_event,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_event_passed,
  output logic [pwes_pkg::CntW-1:0]           out_matching_particles,
  output logic [pwes_pkg::EvW-1:0]            out_events_seen,
  output logic [pwes_pkg::EvW-1:0]            out_events_passed,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwes_pkg::AddrW-1:0]          paddr,
  input  logic [pwes_pkg::DataW-1:0]          pwdata,
  output logic [pwes_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  pwes_pkg::cfg_t                  cfg;
  pwes_pkg::stg_t                  stg;
  logic                            s1_valid_r, s1_valid_nxt;
  logic                            s1_pvalid_r, s1_last_r;
  logic [pwes_pkg::TypeW-1:0]      s1_type_r;
  logic [ENERGY_BITS-1:0]          s1_energy_r;
  logic [MAX_CUTS-1:0]             hit;
  logic                            adv, accept;

  pwes_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall     = s1_valid_r && !adv;
  assign accept       = in_valid && !in_stall;
  assign s1_valid_nxt = accept || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type_r   <= in_particle_type;
      s1_energy_r <= in_kinetic_energy[ENERGY_BITS-1:0];
      s1_pvalid_r <= in_particle_valid;
      s1_last_r   <= in_last_in_event;
    end
  end

  for (genvar i = 0; i < MAX_CUTS; i++) begin : g_lane
    pwes_match #(
      .ENERGY_BITS (ENERGY_BITS)
    ) u_match (
      .cut    (cfg.cut[i]),
      .ptype  (s1_type_r),
      .energy (s1_energy_r),
      .hit    (hit[i])
    );
  end

  assign stg.valid  = s1_valid_r;
  assign stg.pvalid = s1_pvalid_r;
  assign stg.last   = s1_last_r;

  pwes_event #(
    .MAX_CUTS (MAX_CUTS)
  ) u_event (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .stg                    (stg),
    .hit                    (hit),
    .cuts_in_use            (cfg.cuts_in_use),
    .report_orig            (cfg.report_orig),
    .out_stall              (out_stall),
    .adv                    (adv),
    .out_valid              (out_valid),
    .out_event_passed       (out_event_passed),
    .out_matching_particles (out_matching_particles),
    .out_events_seen        (out_events_seen),
    .out_events_passed      (out_events_passed)
  );

endmodule
